FILE: hw/rtl/gripper_position_controller_defines.svh
// ----------------------------------------------------------------------------
// Gripper position controller assertion macros
// Shared assertion shorthands for the checker of the gripper controller.
// ----------------------------------------------------------------------------
`ifndef GRIPPER_POSITION_CONTROLLER_DEFINES_SVH
`define GRIPPER_POSITION_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gripper controller check failed");

// next-cycle implication, disabled in reset
`define GPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gripper controller check failed");

`endif

FILE: hw/rtl/gpc_pkg.sv
// ----------------------------------------------------------------------------
// Gripper position controller package
// Register map, item and result types and fixed drive constants.
// ----------------------------------------------------------------------------
package gpc_pkg;

  localparam logic signed [7:0] FULL_SPEED    = 8'sd127;
  localparam logic signed [7:0] MANUAL_LIMIT  = 8'sd50;
  localparam logic signed [7:0] MANUAL_MIN    = -8'sd128;
  localparam logic [6:0]        FULL_SPEED_MAG = 7'd127;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPEN_POSITION     = 3'd0,
    CFG_CLOSE_POSITION    = 3'd1,
    CFG_POSITION_DEADBAND = 3'd2,
    CFG_MOTION_THRESHOLD  = 3'd3,
    CFG_UPPER_LIMIT       = 3'd4,
    CFG_CREEP_SPEED       = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    MOVE_FULL  = 2'd0,
    MOVE_HOLD  = 2'd1,
    MOVE_CREEP = 2'd2
  } move_status_t;

  typedef struct packed {
    logic [11:0] open_position;
    logic [11:0] close_position;
    logic [9:0]  position_deadband;
    logic [11:0] motion_threshold;
    logic [11:0] upper_limit;
    logic [6:0]  creep_speed;
  } gpc_cfg_t;

  typedef struct packed {
    logic        manual_mode;
    logic        auto_target_close;
    logic [11:0] last_pot_raw;
  } gpc_state_t;

  typedef struct packed {
    logic [11:0]        pot_raw;
    logic signed [13:0] pot_scaled;
    logic signed [7:0]  manual_speed;
    logic               open_button;
    logic               close_button;
  } gpc_item_t;

  typedef struct packed {
    logic signed [7:0] motor_a_speed;
    logic signed [7:0] motor_b_speed;
    logic              manual_active;
    move_status_t      move_status;
    logic              target_done;
  } gpc_result_t;

endpackage

FILE: hw/rtl/gpc_step.sv
// ----------------------------------------------------------------------------
// Gripper controller tick logic
// Mode select, bang-bang auto move with deadband, soft limits for one item.
// ----------------------------------------------------------------------------
module gpc_step import gpc_pkg::*; (
  input  gpc_item_t   item,
  input  gpc_cfg_t    cfg,
  input  gpc_state_t  state,
  output gpc_result_t result,
  output gpc_state_t  state_next
);

  logic signed [7:0]  man;
  logic signed [13:0] pos;
  logic               man_cmd;
  logic [11:0]        target;
  logic signed [14:0] err;
  logic [14:0]        aerr;
  logic signed [12:0] mv;
  logic [12:0]        amv;
  logic               fast;
  logic [6:0]         mag;
  logic               hold;
  logic signed [7:0]  drive_auto;
  move_status_t       status;
  logic               done;
  logic signed [7:0]  drive_pre;
  logic signed [7:0]  drive;

  always_comb begin
    man = item.manual_speed;
    pos = item.pot_scaled;
    man_cmd = (man > MANUAL_LIMIT) || (man < -MANUAL_LIMIT);

    state_next = state;
    state_next.last_pot_raw = item.pot_raw;
    if (man_cmd) begin
      state_next.manual_mode = 1'b1;
    end else if (item.open_button) begin
      state_next.manual_mode       = 1'b0;
      state_next.auto_target_close = 1'b0;
    end else if (item.close_button) begin
      state_next.manual_mode       = 1'b0;
      state_next.auto_target_close = 1'b1;
    end

    target = state_next.auto_target_close ? cfg.close_position : cfg.open_position;
    err    = $signed({3'b000, target}) - $signed({pos[13], pos});
    aerr   = err[14] ? 15'(-err) : 15'(err);
    mv     = $signed({1'b0, item.pot_raw}) - $signed({1'b0, state.last_pot_raw});
    amv    = mv[12] ? 13'(-mv) : 13'(mv);
    fast   = amv > {1'b0, cfg.motion_threshold};
    mag    = fast ? FULL_SPEED_MAG : cfg.creep_speed;
    hold   = aerr < {5'b00000, cfg.position_deadband};

    drive_auto = '0;
    status     = MOVE_HOLD;
    if (hold) begin
      status = MOVE_HOLD;
    end else if (!err[14] && (err != '0) && !state_next.auto_target_close) begin
      drive_auto = $signed({1'b0, mag});
      status     = fast ? MOVE_FULL : MOVE_CREEP;
    end else if (err[14] && state_next.auto_target_close) begin
      drive_auto = -$signed({1'b0, mag});
      status     = fast ? MOVE_FULL : MOVE_CREEP;
    end

    // close counts creeping as done, open only holding
    if (state_next.auto_target_close) begin
      done = (status == MOVE_HOLD) || (status == MOVE_CREEP);
    end else begin
      done = (status == MOVE_HOLD);
    end

    if (state_next.manual_mode) begin
      drive_pre = (man == MANUAL_MIN) ? -FULL_SPEED : man;
    end else begin
      drive_pre = drive_auto;
    end

    // soft end limits
    drive = drive_pre;
    if (pos[13]) begin
      if (drive_pre[7]) begin
        drive = '0;
      end
    end else if (pos > $signed({2'b00, cfg.upper_limit})) begin
      if (!drive_pre[7] && (drive_pre != '0)) begin
        drive = '0;
      end
    end

    result.motor_a_speed = drive;
    result.motor_b_speed = -drive;
    result.manual_active = state_next.manual_mode;
    result.move_status   = state_next.manual_mode ? MOVE_FULL : status;
    result.target_done   = state_next.manual_mode ? 1'b0 : done;
  end

endmodule

FILE: hw/rtl/gripper_position_controller.sv
// ----------------------------------------------------------------------------
// Gripper position controller
// Manual / auto open-close drive for a two-motor gripper, one tick per item.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle at full rate while no result waits on
// result_stall. An item is held in an input register, the combinational tick
// logic works on it, and the result is loaded into the output register once
// that register is empty or its result is taken. The input register is a
// holding stage: one more item is taken while a result waits on result_stall.
// Configuration is written through cfg_valid/cfg_ready, which is always ready;
// writes to indexes above 5 are dropped. After reset the block is in manual
// mode with the open target selected.
module gripper_position_controller import gpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [11:0]           pot_raw,
  input  logic signed [13:0]    pot_scaled,
  input  logic signed [7:0]     manual_speed,
  input  logic                  open_button,
  input  logic                  close_button,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic signed [7:0]     motor_a_speed,
  output logic signed [7:0]     motor_b_speed,
  output logic                  manual_active,
  output logic [1:0]            move_status,
  output logic                  target_done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  gpc_cfg_t    cfg;
  gpc_state_t  state;
  gpc_state_t  state_next;
  gpc_item_t   item_q;
  logic        item_full;
  gpc_result_t result_q;
  gpc_result_t result_next;
  logic        advance;
  logic        take;

  assign cfg_ready  = 1'b1;
  assign advance    = item_full && (!result_valid || !result_stall);
  assign item_stall = item_full && !advance;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_position     <= 12'd0;
      cfg.close_position    <= 12'd3276;
      cfg.position_deadband <= 10'd164;
      cfg.motion_threshold  <= 12'd15;
      cfg.upper_limit       <= 12'd3686;
      cfg.creep_speed       <= 7'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OPEN_POSITION:     cfg.open_position     <= cfg_data;
        CFG_CLOSE_POSITION:    cfg.close_position    <= cfg_data;
        CFG_POSITION_DEADBAND: cfg.position_deadband <= cfg_data[9:0];
        CFG_MOTION_THRESHOLD:  cfg.motion_threshold  <= cfg_data;
        CFG_UPPER_LIMIT:       cfg.upper_limit       <= cfg_data;
        CFG_CREEP_SPEED:       cfg.creep_speed       <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // control: occupancy flags and tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full               <= 1'b0;
      result_valid            <= 1'b0;
      state.manual_mode       <= 1'b1;
      state.auto_target_close <= 1'b0;
      state.last_pot_raw      <= 12'd0;
    end else begin
      if (take) begin
        item_full <= 1'b1;
      end else if (advance) begin
        item_full <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        state        <= state_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      item_q.pot_raw      <= pot_raw;
      item_q.pot_scaled   <= pot_scaled;
      item_q.manual_speed <= manual_speed;
      item_q.open_button  <= open_button;
      item_q.close_button <= close_button;
    end
    if (advance) begin
      result_q <= result_next;
    end
  end

  gpc_step u_step (
    .item       (item_q),
    .cfg        (cfg),
    .state      (state),
    .result     (result_next),
    .state_next (state_next)
  );

  assign motor_a_speed = result_q.motor_a_speed;
  assign motor_b_speed = result_q.motor_b_speed;
  assign manual_active = result_q.manual_active;
  assign move_status   = result_q.move_status;
  assign target_done   = result_q.target_done;

endmodule

FILE: hw/rtl/gpc_checker.sv
// ----------------------------------------------------------------------------
// Gripper controller checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "gripper_position_controller_defines.svh"

module gpc_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input logic signed [7:0] motor_a_speed,
  input logic signed [7:0] motor_b_speed,
  input logic              manual_active,
  input logic [1:0]        move_status,
  input logic              target_done
);

  // the two motors always run opposite
  `GPC_ASSERT_NOW(a_motors_opposite, result_valid, (motor_a_speed + motor_b_speed) == 8'sd0)

  // drive stays in range and status code is legal
  `GPC_ASSERT_NOW(a_drive_range, result_valid,
    (motor_a_speed != -8'sd128) && (move_status != 2'd3))

  // manual items report full-speed status and never target done
  `GPC_ASSERT_NOW(a_manual_status, result_valid && manual_active,
    (move_status == 2'd0) && !target_done)

  // holding in auto means no drive
  `GPC_ASSERT_NOW(a_hold_no_drive, result_valid && !manual_active && (move_status == 2'd1),
    motor_a_speed == 8'sd0)

  `GPC_ASSERT_NEXT(a_stall_hold, result_valid && result_stall,
    result_valid && $stable(motor_a_speed) && $stable(move_status))

endmodule

bind gripper_position_controller gpc_checker u_gpc_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .motor_a_speed (motor_a_speed),
  .motor_b_speed (motor_b_speed),
  .manual_active (manual_active),
  .move_status   (move_status),
  .target_done   (target_done)
);
